### rtl/hashed_set_assoc_code_cache_macros.svh
// Assertion helpers for the checker of this block.
`ifndef HASHED_SET_ASSOC_CODE_CACHE_MACROS_SVH
`define HASHED_SET_ASSOC_CODE_CACHE_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define HCC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hcc assertion failed");

// Condition that must never be seen at a clock edge.
`define HCC_NEVER(lbl, clk, rst_n, cond) \
	`HCC_ASSERT(lbl, clk, rst_n, !(cond))

`endif

### rtl/hcc_pkg.sv
package hcc_pkg;

	// request function codes
	localparam logic [1:0] F_PROBE    = 2'd0;
	localparam logic [1:0] F_CMP_WORD = 2'd1;
	localparam logic [1:0] F_INS_BEGIN = 2'd2;
	localparam logic [1:0] F_INS_WORD = 2'd3;

	// result status codes
	localparam logic [2:0] S_MISS     = 3'd0;
	localparam logic [2:0] S_AWAIT    = 3'd1;
	localparam logic [2:0] S_HIT      = 3'd2;
	localparam logic [2:0] S_STALE    = 3'd3;
	localparam logic [2:0] S_INSERTED = 3'd4;

	// golden-ratio multiplier, split in halves
	localparam logic [31:0] GOLDEN_LO = 32'h7f4a7c15;
	localparam logic [31:0] GOLDEN_HI = 32'h9e3779b9;

	typedef struct packed {
		logic [1:0]  func;
		logic [61:0] key_address;
		logic [31:0] code_word;
		logic [10:0] snapshot_length;
		logic [63:0] payload_in;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] payload_out;
		logic [10:0] words_needed;
	} rsp_t;

	// one way of a tag row
	typedef struct packed {
		logic [61:0] key;
		logic [10:0] len;
		logic [63:0] pay;
	} tag_t;

endpackage

### rtl/hcc_if.sv
// request channel into the cache
interface hcc_req_if;
	logic          valid;
	logic          ready;
	hcc_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// result channel out of the cache
interface hcc_rsp_if;
	logic          valid;
	logic          ready;
	hcc_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/hcc_ram.sv
// Simple dual-port RAM, registered read.
module hcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

### rtl/hcc_hash.sv
// Set index from the golden-ratio hash, one multiply per cycle.
module hcc_hash #(
	parameter int SET_COUNT = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [61:0]                  key,
	output logic                         done,
	output logic [$clog2(SET_COUNT)-1:0] set_idx
);
	import hcc_pkg::*;

	localparam int SET_W = $clog2(SET_COUNT);
	localparam logic [2:0] STEP_LAST = 3'd5;

	logic [2:0]  cnt_q;
	logic [61:0] x_q;
	logic [63:0] m0_q;
	logic [31:0] m1_q, m2_q, hi_q;
	logic [63:0] p1, p2;
	logic [42:0] scaled;

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 3'd1;
		end else if (cnt_q == STEP_LAST) begin
			cnt_q <= '0;
		end else if (cnt_q != 3'd0) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	assign p1 = {34'd0, x_q[61:32]} * {32'd0, GOLDEN_LO};
	assign p2 = {32'd0, x_q[31:0]} * {32'd0, GOLDEN_HI};

	// partial products of (x * golden) mod 2^64, upper word only
	always_ff @(posedge clk) begin
		if (start) x_q <= key ^ (key >> 16);
		case (cnt_q)
			3'd1: m0_q <= {32'd0, x_q[31:0]} * {32'd0, GOLDEN_LO};
			3'd2: m1_q <= p1[31:0];
			3'd3: m2_q <= p2[31:0];
			3'd4: hi_q <= m0_q[63:32] + m1_q + m2_q;
			default: ;
		endcase
	end

	// scale the upper word to the set count
	assign scaled  = {11'd0, hi_q} * 43'(SET_COUNT);
	assign set_idx = scaled[32 +: SET_W];
	assign done    = (cnt_q == STEP_LAST);
endmodule

### rtl/hashed_set_assoc_code_cache.sv
// Hashed set-associative code cache.
// Channels: req (func, key_address, code_word, snapshot_length, payload_in)
// and rsp (status, payload_out, words_needed), valid/ready on each.
// A probe or insert begin with a nonzero address runs the hash unit
// (ST_HASH), reads the tag row and then decides in ST_LOOK, which loads
// the result register and returns to ST_IDLE for the next request. A
// compare word reads the snapshot memory at acceptance and is compared
// in the cycle after (ST_CMP), where the last word answers; an insert
// word writes the snapshot memory at acceptance. Other requests stay in
// ST_IDLE. One request is in work at a time: req.ready is low outside
// ST_IDLE.
// Results wait in an output register; while it is full and rsp.ready is
// low, req.ready stays low.
// Reset clears all valid bits, replacement pointers and the mode; tag and
// snapshot memories are not cleared, reads are gated by the valid bits.
module hashed_set_assoc_code_cache #(
	parameter int SET_COUNT      = 32,
	parameter int WAY_COUNT      = 4,
	parameter int MAX_CODE_WORDS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	hcc_req_if.sink   req,
	hcc_rsp_if.source rsp
);
	import hcc_pkg::*;

	localparam int ENTRY_COUNT = SET_COUNT * WAY_COUNT;
	localparam int SET_W  = $clog2(SET_COUNT);
	localparam int WAY_W  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
	localparam int EN_W   = $clog2(ENTRY_COUNT);
	localparam int CUR_W  = $clog2(MAX_CODE_WORDS + 1);
	localparam int CW     = CUR_W + 1;
	localparam int ADDR_W = $clog2(ENTRY_COUNT * MAX_CODE_WORDS);
	localparam int ROW_W  = WAY_COUNT * $bits(tag_t);

	typedef enum logic [1:0] {ST_IDLE, ST_HASH, ST_LOOK, ST_CMP} state_t;
	typedef enum logic [1:0] {M_IDLE, M_CMP, M_INS} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	req_t              req_q;
	logic [SET_W-1:0]  set_q;
	logic [CUR_W-1:0]  cursor_q;
	logic              mism_q;
	logic [10:0]       len_q;
	logic [63:0]       pay_q;
	logic [EN_W-1:0]   en_q;
	logic [ADDR_W-1:0] base_q;
	logic [ENTRY_COUNT-1:0] valid_q;
	logic [WAY_W-1:0]  rp_q [SET_COUNT];
	logic              out_v_q;
	rsp_t              out_q;

	logic              fire, is_begin, key_zero;
	logic              out_load;
	logic              hash_done;
	logic [SET_W-1:0]  hash_set;
	tag_t [WAY_COUNT-1:0] row, new_row;
	logic              hit_any;
	logic [WAY_W-1:0]  hit_way, ins_way, rp_next;
	logic [EN_W-1:0]   hit_en, ins_en;
	logic [10:0]       ins_len;
	logic              tag_we;
	logic              snap_we, snap_re;
	logic [ADDR_W-1:0] snap_addr;
	logic [31:0]       snap_rdata;
	logic [CW-1:0]     cur_next;
	logic              cur_last, cur_ok;
	logic              mism_n;

	assign req.ready = (state_q == ST_IDLE) && (!out_v_q || rsp.ready);
	assign fire      = req.valid && req.ready;
	assign is_begin  = (req.data.func == F_PROBE) || (req.data.func == F_INS_BEGIN);
	assign key_zero  = (req.data.key_address == 62'd0);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	// cursor progress, shared by compare and insert words
	assign cur_next = CW'(cursor_q) + CW'(1);
	assign cur_last = (cur_next >= CW'(len_q));
	assign cur_ok   = (32'(cursor_q) < 32'(MAX_CODE_WORDS));
	assign snap_addr = base_q + ADDR_W'(cursor_q);
	assign snap_we  = fire && (req.data.func == F_INS_WORD) && (mode_q == M_INS) && cur_ok;
	assign snap_re  = fire && (req.data.func == F_CMP_WORD) && (mode_q == M_CMP) && cur_ok;
	assign mism_n   = mism_q || (snap_rdata != req_q.code_word);

	// a result enters the output register this cycle
	assign out_load = (state_q == ST_LOOK) || ((state_q == ST_CMP) && cur_last) ||
	                  (fire && is_begin && key_zero) || (snap_we && cur_last);

	hcc_hash #(.SET_COUNT(SET_COUNT)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fire && is_begin && !key_zero),
		.key    (req.data.key_address),
		.done   (hash_done),
		.set_idx(hash_set)
	);

	hcc_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_tags (
		.clk  (clk),
		.we   (tag_we),
		.waddr(set_q),
		.wdata(new_row),
		.re   (hash_done),
		.raddr(hash_set),
		.rdata(row)
	);

	hcc_ram #(.WIDTH(32), .DEPTH(ENTRY_COUNT * MAX_CODE_WORDS)) u_snap (
		.clk  (clk),
		.we   (snap_we),
		.waddr(snap_addr),
		.wdata(req.data.code_word),
		.re   (snap_re),
		.raddr(snap_addr),
		.rdata(snap_rdata)
	);

	// way match in the fetched row, lowest way wins
	always_comb begin
		hit_any = 1'b0;
		hit_way = '0;
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (valid_q[EN_W'(int'(set_q) * WAY_COUNT + w)] &&
			    row[w].key == req_q.key_address) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	// insert target and new tag row
	always_comb begin
		ins_way = hit_any ? hit_way : rp_q[set_q];
		rp_next = (int'(rp_q[set_q]) == WAY_COUNT - 1) ? '0 : rp_q[set_q] + WAY_W'(1);
		hit_en  = EN_W'(int'(set_q) * WAY_COUNT + int'(hit_way));
		ins_en  = EN_W'(int'(set_q) * WAY_COUNT + int'(ins_way));
		ins_len = (32'(req_q.snapshot_length) > 32'(MAX_CODE_WORDS)) ?
		          11'(MAX_CODE_WORDS) : req_q.snapshot_length;
		new_row = row;
		new_row[ins_way] = '{key: req_q.key_address, len: ins_len, pay: req_q.payload_in};
		tag_we  = (state_q == ST_LOOK) && (req_q.func == F_INS_BEGIN);
	end

	// sequencer, mode and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= M_IDLE;
			cursor_q <= '0;
			mism_q   <= 1'b0;
			valid_q  <= '0;
			out_v_q  <= 1'b0;
			for (int s = 0; s < SET_COUNT; s++) rp_q[s] <= '0;
		end else begin
			if (rsp.ready && !out_load) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (fire) begin
						req_q <= req.data;
						if (is_begin) begin
							mode_q <= M_IDLE;
							if (key_zero) begin
								out_v_q <= 1'b1;
								out_q   <= '{status: S_MISS, payload_out: '0, words_needed: '0};
							end else begin
								state_q <= ST_HASH;
							end
						end else if (snap_re) begin
							state_q <= ST_CMP;
						end else if (snap_we) begin
							cursor_q <= cur_next[CUR_W-1:0];
							if (cur_last) begin
								valid_q[en_q] <= 1'b1;
								mode_q  <= M_IDLE;
								out_v_q <= 1'b1;
								out_q   <= '{status: S_INSERTED, payload_out: '0,
								             words_needed: '0};
							end
						end
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						set_q   <= hash_set;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q  <= ST_IDLE;
					out_v_q  <= 1'b1;
					cursor_q <= '0;
					mism_q   <= 1'b0;
					if (req_q.func == F_PROBE) begin
						en_q   <= hit_en;
						base_q <= ADDR_W'(hit_en) * ADDR_W'(MAX_CODE_WORDS);
						len_q  <= row[hit_way].len;
						pay_q  <= row[hit_way].pay;
						if (!hit_any) begin
							out_q <= '{status: S_MISS, payload_out: '0, words_needed: '0};
						end else if (row[hit_way].len == 11'd0) begin
							out_q <= '{status: S_HIT, payload_out: row[hit_way].pay,
							           words_needed: '0};
						end else begin
							mode_q <= M_CMP;
							out_q  <= '{status: S_AWAIT, payload_out: '0,
							            words_needed: row[hit_way].len};
						end
					end else begin
						if (!hit_any) rp_q[set_q] <= rp_next;
						en_q   <= ins_en;
						base_q <= ADDR_W'(ins_en) * ADDR_W'(MAX_CODE_WORDS);
						len_q  <= ins_len;
						if (ins_len == 11'd0) begin
							valid_q[ins_en] <= 1'b1;
							out_q <= '{status: S_INSERTED, payload_out: '0, words_needed: '0};
						end else begin
							valid_q[ins_en] <= 1'b0;
							mode_q <= M_INS;
							out_q  <= '{status: S_AWAIT, payload_out: '0, words_needed: ins_len};
						end
					end
				end
				ST_CMP: begin
					state_q  <= ST_IDLE;
					mism_q   <= mism_n;
					cursor_q <= cur_next[CUR_W-1:0];
					if (cur_last) begin
						mode_q  <= M_IDLE;
						out_v_q <= 1'b1;
						if (mism_n) begin
							out_q <= '{status: S_STALE, payload_out: '0, words_needed: '0};
						end else begin
							out_q <= '{status: S_HIT, payload_out: pay_q, words_needed: '0};
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/hcc_checker.sv
`include "hashed_set_assoc_code_cache_macros.svh"

// Port-level checks of the cache.
module hcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  status,
	input logic [63:0] payload_out,
	input logic [10:0] words_needed
);
	import hcc_pkg::*;

	logic        rsp_stall;
	logic [77:0] rsp_word;

	assign rsp_stall = rsp_valid && !rsp_ready;
	assign rsp_word  = {status, payload_out, words_needed};

	// stalled result holds
	`HCC_ASSERT(a_rsp_hold, clk, arst_n, rsp_stall |=> rsp_valid && $stable(rsp_word))
	// no request taken while the result register is blocked
	`HCC_NEVER(a_no_accept_full, clk, arst_n, rsp_stall && req_ready)
	// payload only comes with a hit
	`HCC_NEVER(a_pay_hit, clk, arst_n, rsp_valid && payload_out != 64'd0 && status != S_HIT)
	// word count only comes with await
	`HCC_NEVER(a_need_await, clk, arst_n, rsp_valid && words_needed != 11'd0 && status != S_AWAIT)
	// status is always a defined code
	`HCC_ASSERT(a_status_code, clk, arst_n, rsp_valid |-> status <= S_INSERTED)
endmodule

bind hashed_set_assoc_code_cache hcc_checker u_hcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.data.status),
	.payload_out (rsp.data.payload_out),
	.words_needed(rsp.data.words_needed)
);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hcc_pkg::*;

	localparam int SETS = 32;
	localparam int WAYS = 4;
	localparam int MAXW = 1024;
	localparam logic [63:0] GOLD = 64'h9e3779b97f4a7c15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hcc_req_if req ();
	hcc_rsp_if rsp ();

	hashed_set_assoc_code_cache DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	typedef enum logic [1:0] {M_IDLE, M_CMP, M_INS} mode_e;
	bit          c_valid [SETS*WAYS];
	logic [61:0] c_key   [SETS*WAYS];
	logic [10:0] c_len   [SETS*WAYS];
	logic [63:0] c_pay   [SETS*WAYS];
	logic [31:0] c_words [int];
	logic [1:0]  c_rr    [SETS];
	int          cur_set, cur_way, cur_pos;
	bit          cur_bad;
	mode_e       mode;

	rsp_t expected_q [$];
	int   n_errors = 0;
	bit   hold_rx = 0;

	// known keys (their snapshots come from word_of), for building well-formed streams
	logic [61:0] known_keys [$];

	function automatic int set_index(logic [61:0] a);
		logic [63:0] x, p;
		x = {2'b0, a} ^ ({2'b0, a} >> 16);
		p = x * GOLD;
		return int'(p[63:59]);
	endfunction

	function automatic rsp_t mk(logic [2:0] s, logic [63:0] p, logic [10:0] n);
		rsp_t r;
		r.status = s; r.payload_out = p; r.words_needed = n;
		return r;
	endfunction

	// advance the cache model by one request; push any result
	task automatic cache_predict(req_t r);
		int s, w, e;
		logic [10:0] len;
		w = -1;
		if (r.func == F_PROBE || r.func == F_INS_BEGIN) begin
			mode = M_IDLE;
			if (r.key_address == 0) begin
				expected_q.push_back(mk(S_MISS, 0, 0));
				return;
			end
			s = set_index(r.key_address);
			for (int i = WAYS - 1; i >= 0; i--)
				if (c_valid[s*WAYS+i] && c_key[s*WAYS+i] == r.key_address) w = i;
			if (r.func == F_PROBE) begin
				if (w < 0) begin
					expected_q.push_back(mk(S_MISS, 0, 0));
					return;
				end
				e = s*WAYS + w;
				if (c_len[e] == 0) begin
					expected_q.push_back(mk(S_HIT, c_pay[e], 0));
					return;
				end
				cur_set = s; cur_way = w; cur_pos = 0; cur_bad = 0; mode = M_CMP;
				expected_q.push_back(mk(S_AWAIT, 0, c_len[e]));
				return;
			end
			if (w < 0) begin
				w = c_rr[s];
				c_rr[s] = 2'(c_rr[s] + 2'd1);
			end
			e = s*WAYS + w;
			len = (r.snapshot_length > MAXW) ? 11'(MAXW) : r.snapshot_length;
			c_valid[e] = 0; c_key[e] = r.key_address; c_len[e] = len;
			c_pay[e] = r.payload_in;
			if (len == 0) begin
				c_valid[e] = 1;
				expected_q.push_back(mk(S_INSERTED, 0, 0));
				return;
			end
			cur_set = s; cur_way = w; cur_pos = 0; cur_bad = 0; mode = M_INS;
			expected_q.push_back(mk(S_AWAIT, 0, len));
			return;
		end
		e = cur_set*WAYS + cur_way;
		if (r.func == F_CMP_WORD) begin
			if (mode != M_CMP || cur_pos >= MAXW) return;
			if (c_words[e*MAXW+cur_pos] !== r.code_word) cur_bad = 1;
			cur_pos++;
			if (cur_pos < c_len[e]) return;
			mode = M_IDLE;
			expected_q.push_back(cur_bad ? mk(S_STALE, 0, 0) : mk(S_HIT, c_pay[e], 0));
			return;
		end
		if (mode != M_INS || cur_pos >= MAXW) return;
		c_words[e*MAXW+cur_pos] = r.code_word;
		cur_pos++;
		if (cur_pos < c_len[e]) return;
		c_valid[e] = 1;
		mode = M_IDLE;
		expected_q.push_back(mk(S_INSERTED, 0, 0));
	endtask

	// stimulus queue, filled up front and drained by the sender
	req_t stim_q [$];

	function automatic req_t mkreq(logic [1:0] f, logic [61:0] k, logic [31:0] w,
			logic [10:0] l, logic [63:0] p);
		req_t r;
		r.func = f; r.key_address = k; r.code_word = w;
		r.snapshot_length = l; r.payload_in = p;
		return r;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [61:0] rndkey();
		logic [61:0] k;
		k = 62'({$urandom, $urandom});
		if ($urandom_range(0, 3) == 0) k = 62'($urandom_range(1, 40));
		if (k == 0) k = 1;
		return k;
	endfunction

	// words for key k and index i, deterministic so probes can replay them
	function automatic logic [31:0] word_of(logic [61:0] k, int i);
		return k[31:0] ^ k[61:30] ^ (i * 32'h01000193);
	endfunction

	task automatic add_insert(logic [61:0] k, int len);
		stim_q.push_back(mkreq(F_INS_BEGIN, k, $urandom, 11'(len), rnd64()));
		for (int i = 0; i < len && i < MAXW; i++)
			stim_q.push_back(mkreq(F_INS_WORD, rndkey(), word_of(k, i), 11'($urandom),
				rnd64()));
	endtask

	task automatic add_probe(logic [61:0] k, int len, bit corrupt);
		int bad;
		bad = corrupt ? $urandom_range(0, len > 0 ? len - 1 : 0) : -1;
		stim_q.push_back(mkreq(F_PROBE, k, $urandom, 11'($urandom), rnd64()));
		for (int i = 0; i < len; i++)
			stim_q.push_back(mkreq(F_CMP_WORD, rndkey(),
				(i == bad) ? ~word_of(k, i) : word_of(k, i), 11'($urandom), rnd64()));
	endtask

	// directed table: rows with a fixed answer carry it, others use the predictor
	typedef struct {
		req_t  r;
		bit    fixed;
		rsp_t  ans;
	} row_t;

	row_t table_rows [$];
	int   fixed_checks [int];

	task automatic build_stimulus();
		logic [61:0] k;
		int len;
		// directed rows
		table_rows.push_back('{mkreq(F_PROBE, 62'h0, 0, 0, 0), 1, mk(S_MISS, 0, 0)});
		table_rows.push_back('{mkreq(F_INS_BEGIN, 62'h0, '1, 11'd5, '1), 1, mk(S_MISS, 0, 0)});
		table_rows.push_back('{mkreq(F_PROBE, '1, 0, 0, 0), 1, mk(S_MISS, 0, 0)});
		table_rows.push_back('{mkreq(F_CMP_WORD, 0, '1, 0, 0), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_INS_WORD, 0, '1, 0, 0), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_INS_BEGIN, '1, 0, 11'd0, '1), 1, mk(S_INSERTED, 0, 0)});
		table_rows.push_back('{mkreq(F_PROBE, '1, 0, 0, 0), 1, mk(S_HIT, '1, 0)});
		table_rows.push_back('{mkreq(F_INS_BEGIN, 62'h5, 0, 11'd2047, 64'h1234), 1,
			mk(S_AWAIT, 0, 11'd1024)});
		table_rows.push_back('{mkreq(F_INS_BEGIN, 62'h5, 0, 11'd3, 64'hAB), 1,
			mk(S_AWAIT, 0, 11'd3)});
		table_rows.push_back('{mkreq(F_INS_WORD, 0, 32'h0, 0, 0), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_INS_WORD, 0, '1, 0, 0), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_INS_WORD, 0, 32'h5a5a5a5a, 0, 0), 1,
			mk(S_INSERTED, 0, 0)});
		table_rows.push_back('{mkreq(F_PROBE, 62'h5, 0, 0, 0), 1, mk(S_AWAIT, 0, 11'd3)});
		table_rows.push_back('{mkreq(F_CMP_WORD, 0, 32'h0, 0, 0), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_CMP_WORD, 0, '1, 0, 0), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_CMP_WORD, 0, 32'h5a5a5a5a, 0, 0), 1, mk(S_HIT, 64'hAB, 0)});
		table_rows.push_back('{mkreq(F_PROBE, 62'h5, 0, 0, 0), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_CMP_WORD, 0, 32'h1, 0, 0), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_CMP_WORD, 0, '1, 0, 0), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_CMP_WORD, 0, 32'h5a5a5a5a, 0, 0), 1, mk(S_STALE, 0, 0)});
		// interrupted insert leaves the way invalid
		table_rows.push_back('{mkreq(F_INS_BEGIN, 62'h5, 0, 11'd2, 64'h77), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_INS_WORD, 0, 32'h9, 0, 0), 0, mk(0, 0, 0)});
		table_rows.push_back('{mkreq(F_PROBE, 62'h5, 0, 0, 0), 1, mk(S_MISS, 0, 0)});
		for (int i = 0; i < table_rows.size(); i++) begin
			if (table_rows[i].fixed) fixed_checks[stim_q.size()] = i;
			stim_q.push_back(table_rows[i].r);
		end
		// random part: mostly well-formed insert/probe streams
		while (stim_q.size() < 1250) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					k = rndkey();
					len = ($urandom_range(0, 40) == 0) ? $urandom_range(1000, 1100)
						: $urandom_range(0, 6);
					if ($urandom_range(0, 5) == 0) begin
						// broken insert
						stim_q.push_back(mkreq(F_INS_BEGIN, k, 0, 11'(len + 2), rnd64()));
						stim_q.push_back(mkreq(F_INS_WORD, 0, $urandom, 0, 0));
					end else begin
						add_insert(k, len > MAXW ? MAXW : len);
						if (len > MAXW) len = MAXW;
						known_keys.push_back(k);
					end
				end
				3, 4, 5, 6: begin
					if (known_keys.size() > 0) begin
						k = known_keys[$urandom_range(0, known_keys.size() - 1)];
						add_probe(k, $urandom_range(0, 6), $urandom_range(0, 2) == 0);
					end
				end
				7: stim_q.push_back(mkreq(F_PROBE, rndkey(), 0, 0, 0));
				default: stim_q.push_back(mkreq(2'($urandom_range(0, 3)), rndkey(),
					$urandom, 11'($urandom), rnd64()));
			endcase
		end
	endtask

	// sender
	int sent_idx = 0;
	bit send_done = 0;
	initial begin
		int gap;
		req.valid <= 1'b0;
		req.data <= '0;
		build_stimulus();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (sent_idx < stim_q.size()) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 2) == 0) gap = 0;
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req.valid <= 1'b1;
			req.data <= stim_q[sent_idx];
			@(posedge clk);
			while (!req.ready) @(posedge clk);
			if (fixed_checks.exists(sent_idx)) begin
				int before_n;
				rsp_t fix_r;
				before_n = expected_q.size();
				fix_r = table_rows[fixed_checks[sent_idx]].ans;
				cache_predict(stim_q[sent_idx]);
				if (expected_q.size() > before_n && expected_q[$] !== fix_r) begin
					$error("table row %0d result: expected %0d/%h/%0d, got %0d/%h/%0d",
						fixed_checks[sent_idx], fix_r.status, fix_r.payload_out,
						fix_r.words_needed, expected_q[$].status,
						expected_q[$].payload_out, expected_q[$].words_needed);
					n_errors++;
					expected_q[$] = fix_r;
				end
			end else
				cache_predict(stim_q[sent_idx]);
			sent_idx++;
		end
		req.valid <= 1'b0;
		send_done = 1;
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int gap;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
			if (hold_rx) begin
				rsp.ready <= 1'b0;
				while (hold_rx) @(posedge clk);
			end
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		wait (sent_idx > 300);
		@(posedge clk);
		hold_rx = 1;
		repeat (400) @(posedge clk);
		hold_rx = 0;
	end

	// result checker
	always @(posedge clk) begin
		rsp_t got, exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp.data;
			if (expected_q.size() == 0) begin
				$error("unexpected result status=%0d", got.status);
				n_errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (got.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, got.status);
					n_errors++;
				end
				if (got.payload_out !== exp_r.payload_out) begin
					$error("payload_out: expected %h, got %h", exp_r.payload_out,
						got.payload_out);
					n_errors++;
				end
				if (got.words_needed !== exp_r.words_needed) begin
					$error("words_needed: expected %0d, got %0d", exp_r.words_needed,
						got.words_needed);
					n_errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (send_done);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

### hashed_set_assoc_code_cache.f
+incdir+rtl
rtl/hcc_pkg.sv
rtl/hcc_if.sv
rtl/hcc_ram.sv
rtl/hcc_hash.sv
rtl/hashed_set_assoc_code_cache.sv
rtl/hcc_checker.sv
verif/testbench.sv
